// ----- design/rbsi_pkg.sv -----
package rbsi_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int CSR_IDX_W = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] origin_x;
      logic signed [DATA_W-1:0] origin_y;
      logic signed [DATA_W-1:0] origin_z;
      logic signed [DATA_W-1:0] direction_x;
      logic signed [DATA_W-1:0] direction_y;
      logic signed [DATA_W-1:0] direction_z;
   } ray_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] distance;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] point_z;
   } result_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [DATA_W-1:0]    data;
   } csr_write_type;

endpackage

// ----- design/rbsi_channel_if.sv -----
interface rbsi_channel_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/rbsi_div_cell.sv -----
// One restoring division step on a magnitude. Each cell retires one quotient
// bit for each of the six plane distances of the ray that it holds, and hands
// the partial remainders and quotients to the next cell.
module rbsi_div_cell #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 32,
   parameter int CARRY_W = 96
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid_in,
   input  logic [CARRY_W-1:0]       carry_in,
   input  logic [5:0][NUM_W-1:0]    rem_in,
   input  logic [5:0][DEN_W-1:0]    den_in,
   input  logic [5:0][NUM_W-1:0]    quo_in,
   input  logic [5:0][NUM_W-1:0]    shifted_in,
   output logic                     valid_out,
   output logic [CARRY_W-1:0]       carry_out,
   output logic [5:0][NUM_W-1:0]    rem_out,
   output logic [5:0][DEN_W-1:0]    den_out,
   output logic [5:0][NUM_W-1:0]    quo_out,
   output logic [5:0][NUM_W-1:0]    shifted_out
);
   logic                  valid_ff;
   logic [CARRY_W-1:0]    carry_ff;
   logic [5:0][NUM_W-1:0] rem_ff, rem_in_v, quo_ff, quo_in_v, sh_ff, sh_in;
   logic [5:0][DEN_W-1:0] den_ff;

   // Shift in the next dividend bit, then subtract the divisor if it fits.
   always_comb begin
      logic [NUM_W:0] trial;
      for (int k = 0; k < 6; k++) begin
         trial = {rem_in[k], shifted_in[k][NUM_W-1]};
         sh_in[k] = {shifted_in[k][NUM_W-2:0], 1'b0};
         if (trial >= {{(NUM_W+1-DEN_W){1'b0}}, den_in[k]}) begin
            rem_in_v[k] = NUM_W'(trial - {{(NUM_W+1-DEN_W){1'b0}}, den_in[k]});
            quo_in_v[k] = {quo_in[k][NUM_W-2:0], 1'b1};
         end else begin
            rem_in_v[k] = trial[NUM_W-1:0];
            quo_in_v[k] = {quo_in[k][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         carry_ff <= carry_in;
         rem_ff   <= rem_in_v;
         quo_ff   <= quo_in_v;
         den_ff   <= den_in;
         sh_ff    <= sh_in;
      end
   end

   assign valid_out   = valid_ff;
   assign carry_out   = carry_ff;
   assign rem_out     = rem_ff;
   assign den_out     = den_ff;
   assign quo_out     = quo_ff;
   assign shifted_out = sh_ff;
endmodule

// ----- design/ray_box_slab_intersect.sv -----
// Ray against axis-aligned box, slab method, fully pipelined.
// Pipeline: FRAC_BITS + 33 divider cells, the first loaded on the request transfer
// edge, then five tail stages.
// Throughput: one ray per cycle while not stalled; the divider cell chain sets it.
// A full output register not taken by the receiver stalls the whole chain in place.
// Reset: synchronous, active high; clears valid bits and box registers to 0.
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   rbsi_channel_if.sink   req,
   rbsi_channel_if.source rsp,
   rbsi_channel_if.sink   csr
);
   import rbsi_pkg::*;

   localparam int W      = DATA_W;
   localparam int NUM_W  = W + 1 + FRAC_BITS;   // |plane - origin| << FRAC_BITS
   localparam int STEPS  = NUM_W;
   localparam int CARRY_W = 6 * W + 6 + 6 + 6;  // ray, signs, zero flags, num signs

   ray_type       ray;
   csr_write_type cw;
   assign ray = req.payload;
   assign cw  = csr.payload;

   // Box registers.
   logic signed [2:0][W-1:0] bmin_ff, bmax_ff;
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bmin_ff <= '0;
         bmax_ff <= '0;
      end else if (csr.valid) begin
         unique case (cw.index)
            CSR_BOX_MIN_X: bmin_ff[0] <= cw.data;
            CSR_BOX_MIN_Y: bmin_ff[1] <= cw.data;
            CSR_BOX_MIN_Z: bmin_ff[2] <= cw.data;
            CSR_BOX_MAX_X: bmax_ff[0] <= cw.data;
            CSR_BOX_MAX_Y: bmax_ff[1] <= cw.data;
            CSR_BOX_MAX_Z: bmax_ff[2] <= cw.data;
            default: ;
         endcase
      end
   end

   // Stall: the whole pipe advances unless the output holds a result not yet taken.
   logic out_valid_ff;
   logic enable;
   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable;

   // Input stage: numerators and magnitudes for the six plane distances.
   // Slot 2k is the lower plane of axis k, slot 2k+1 the upper plane.
   // For a zero direction, nneg marks the slots that saturate to the most
   // negative distance: a negative numerator, or a zero one on the lower plane.
   logic [5:0][W-1:0]     den0;
   logic [5:0][NUM_W-1:0] sh0;
   logic [5:0]            nneg0, neg0, dz0;
   logic [CARRY_W-1:0]    carry0;
   always_comb begin
      logic signed [W-1:0] org, dir, lo, hi;
      logic signed [W:0]   num;
      logic [W:0]          mag;
      for (int k = 0; k < 3; k++) begin
         org = ray[W*(5-k) +: W];
         dir = ray[W*(2-k) +: W];
         lo = ($signed(bmin_ff[k]) < $signed(bmax_ff[k])) ? bmin_ff[k] : bmax_ff[k];
         hi = ($signed(bmin_ff[k]) < $signed(bmax_ff[k])) ? bmax_ff[k] : bmin_ff[k];
         for (int j = 0; j < 2; j++) begin
            num = (j == 0) ? ((W+1)'(lo) - (W+1)'(org)) : ((W+1)'(hi) - (W+1)'(org));
            mag = num[W] ? (W+1)'(-num) : num;
            sh0[2*k+j]   = {mag, {FRAC_BITS{1'b0}}};
            den0[2*k+j]  = dir[W-1] ? W'(-dir) : dir;
            nneg0[2*k+j] = num[W] || ((num == '0) && (j == 0));
            neg0[2*k+j]  = num[W] ^ dir[W-1];
            dz0[2*k+j]   = (dir == '0);
         end
      end
      carry0 = {ray, nneg0, neg0, dz0};
   end

   // Divider cell chain.
   logic [STEPS:0]                 cv;
   logic [STEPS:0][CARRY_W-1:0]    cc;
   logic [STEPS:0][5:0][NUM_W-1:0] crem, cquo, csh;
   logic [STEPS:0][5:0][W-1:0]     cden;
   assign cv[0]   = req.valid;
   assign cc[0]   = carry0;
   assign crem[0] = '0;
   assign cquo[0] = '0;
   assign csh[0]  = sh0;
   assign cden[0] = den0;

   for (genvar s = 0; s < STEPS; s++) begin : g_cell
      rbsi_div_cell #(.NUM_W(NUM_W), .DEN_W(W), .CARRY_W(CARRY_W)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(cv[s]), .carry_in(cc[s]), .rem_in(crem[s]), .den_in(cden[s]),
         .quo_in(cquo[s]), .shifted_in(csh[s]),
         .valid_out(cv[s+1]), .carry_out(cc[s+1]), .rem_out(crem[s+1]),
         .den_out(cden[s+1]), .quo_out(cquo[s+1]), .shifted_out(csh[s+1])
      );
   end

   // Tail stage 1: sign, saturation, zero-direction cases.
   ray_type            ray_t;
   logic [5:0]         nneg_t, neg_t, dz_t;
   assign {ray_t, nneg_t, neg_t, dz_t} = cc[STEPS];
   logic [5:0][W-1:0]  tq_in, tq_ff;
   logic               v1_ff;
   ray_type            ray1_ff;
   always_comb begin
      logic [NUM_W-1:0] q;
      for (int k = 0; k < 6; k++) begin
         q = cquo[STEPS][k];
         if (dz_t[k]) begin
            // The chain quotient means nothing here; the side was fixed at the input.
            if (nneg_t[k]) tq_in[k] = {1'b1, {(W-1){1'b0}}};
            else           tq_in[k] = {1'b0, {(W-1){1'b1}}};
         end else if (neg_t[k]) begin
            if (q > NUM_W'(64'h8000_0000)) tq_in[k] = {1'b1, {(W-1){1'b0}}};
            else tq_in[k] = W'(-q);
         end else begin
            if (q > NUM_W'(64'h7fff_ffff)) tq_in[k] = {1'b0, {(W-1){1'b1}}};
            else tq_in[k] = q[W-1:0];
         end
      end
   end

   // Tail stage 2: per-axis near and far.
   logic signed [2:0][W-1:0] near_ff, far_ff;
   logic                     v2_ff;
   ray_type                  ray2_ff;
   // Tail stage 3: entry and exit.
   logic signed [W-1:0]      tent_ff, texit_ff;
   logic                     v3_ff;
   ray_type                  ray3_ff;
   // Tail stage 4: products.
   logic signed [2:0][2*W-1:0] prod_ff;
   logic                       v4_ff, hit4_ff;
   logic signed [W-1:0]        tent4_ff;
   ray_type                    ray4_ff;

   logic signed [2:0][W-1:0] near_in, far_in;
   always_comb begin
      logic signed [W-1:0] a, b;
      for (int k = 0; k < 3; k++) begin
         a = tq_ff[2*k];
         b = tq_ff[2*k+1];
         near_in[k] = (a < b) ? a : b;
         far_in[k]  = (a < b) ? b : a;
      end
   end

   logic signed [W-1:0] tent_in, texit_in;
   always_comb begin
      tent_in  = near_ff[0];
      texit_in = far_ff[0];
      for (int k = 1; k < 3; k++) begin
         if ($signed(near_ff[k]) > tent_in)  tent_in  = near_ff[k];
         if ($signed(far_ff[k])  < texit_in) texit_in = far_ff[k];
      end
   end

   logic signed [2:0][2*W-1:0] prod_in;
   always_comb begin
      prod_in[0] = ray3_ff.direction_x * tent_ff;
      prod_in[1] = ray3_ff.direction_y * tent_ff;
      prod_in[2] = ray3_ff.direction_z * tent_ff;
   end

   // Tail stage 5: shift, add, saturate into the output register.
   result_type res_in, res_ff;
   always_comb begin
      logic signed [2*W-1:0] s;
      logic signed [2*W:0]   sum;
      logic signed [W-1:0]   org;
      logic signed [W-1:0]   pt [3];
      for (int k = 0; k < 3; k++) begin
         org = ray4_ff[W*(5-k) +: W];
         s   = $signed(prod_ff[k]) >>> FRAC_BITS;
         sum = (2*W+1)'(s) + (2*W+1)'(org);
         if (!hit4_ff) pt[k] = org;
         else if (sum > (2*W+1)'(64'sh7fff_ffff)) pt[k] = {1'b0, {(W-1){1'b1}}};
         else if (sum < -(2*W+1)'(64'sh8000_0000)) pt[k] = {1'b1, {(W-1){1'b0}}};
         else pt[k] = sum[W-1:0];
      end
      res_in.hit      = hit4_ff;
      res_in.distance = hit4_ff ? tent4_ff : -(W'(1) << FRAC_BITS);
      res_in.point_x  = pt[0];
      res_in.point_y  = pt[1];
      res_in.point_z  = pt[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= cv[STEPS];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         out_valid_ff <= v4_ff;
      end
      if (enable) begin
         tq_ff    <= tq_in;
         ray1_ff  <= ray_t;
         near_ff  <= near_in;
         far_ff   <= far_in;
         ray2_ff  <= ray1_ff;
         tent_ff  <= tent_in;
         texit_ff <= texit_in;
         ray3_ff  <= ray2_ff;
         prod_ff  <= prod_in;
         hit4_ff  <= (texit_ff >= tent_ff);
         tent4_ff <= tent_ff;
         ray4_ff  <= ray3_ff;
         res_ff   <= res_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = res_ff;
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import rbsi_pkg::*;

   localparam int LATENCY    = FRAC_BITS + 39;
   localparam int WATCHDOG   = 5000;
   localparam int RANDOM_RAYS = 1200;

   logic clock;
   logic reset;

   rbsi_channel_if #(.payload_type(ray_type))       req_if ();
   rbsi_channel_if #(.payload_type(result_type))    rsp_if ();
   rbsi_channel_if #(.payload_type(csr_write_type)) csr_if ();

   ray_box_slab_intersect u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   // Box bounds as the predictor sees them.
   logic signed [31:0] box_lo_reg [3];
   logic signed [31:0] box_hi_reg [3];

   result_type hit_queue [$];
   int         error_count;
   int         idle_cycles;
   bit         stall_enable;

   // Directed rays; expected result typed in where obvious.
   typedef struct {
      ray_type    ray;
      bit         has_expect;
      result_type expected;
   } ray_row_type;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] sat_q(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Plane distance: (num << FRAC_BITS) / den, truncated, saturated.
   function automatic logic signed [63:0] plane_distance(input logic signed [63:0] num,
         input logic signed [63:0] den, input bit zero_high);
      logic [63:0] un, ud, q;
      bit          negative;
      if (den == 0) begin
         if (num > 0) return 64'sd2147483647;
         if (num < 0) return -64'sd2147483648;
         return zero_high ? 64'sd2147483647 : -64'sd2147483648;
      end
      negative = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q  = (un << FRAC_BITS) / ud;
      if (negative) begin
         if (q > 64'd2147483648) return -64'sd2147483648;
         return -$signed(q);
      end
      if (q > 64'd2147483647) return 64'sd2147483647;
      return $signed(q);
   endfunction

   // Entry point coordinate: floor shift of the exact product, then saturate.
   function automatic logic signed [31:0] entry_coord(input logic signed [63:0] org,
         input logic signed [63:0] dir, input logic signed [63:0] t);
      logic signed [63:0] p;
      p = dir * t;
      return 32'(sat_q(org + (p >>> FRAC_BITS)));
   endfunction

   function automatic result_type slab_intersect(input ray_type r);
      logic signed [63:0] org [3];
      logic signed [63:0] dir [3];
      logic signed [63:0] t_enter, t_exit, lo, hi, t1, t2;
      result_type         res;
      org[0] = r.origin_x;    org[1] = r.origin_y;    org[2] = r.origin_z;
      dir[0] = r.direction_x; dir[1] = r.direction_y; dir[2] = r.direction_z;
      t_enter = -64'sd2147483648;
      t_exit  = 64'sd2147483647;
      for (int i = 0; i < 3; i++) begin
         lo = (box_lo_reg[i] < box_hi_reg[i]) ? box_lo_reg[i] : box_hi_reg[i];
         hi = (box_lo_reg[i] < box_hi_reg[i]) ? box_hi_reg[i] : box_lo_reg[i];
         t1 = plane_distance(lo - org[i], dir[i], 1'b0);
         t2 = plane_distance(hi - org[i], dir[i], 1'b1);
         if (((t1 < t2) ? t1 : t2) > t_enter) t_enter = (t1 < t2) ? t1 : t2;
         if (((t1 < t2) ? t2 : t1) < t_exit) t_exit = (t1 < t2) ? t2 : t1;
      end
      if (t_exit >= t_enter) begin
         res.hit      = 1'b1;
         res.distance = t_enter[31:0];
         res.point_x  = entry_coord(org[0], dir[0], t_enter);
         res.point_y  = entry_coord(org[1], dir[1], t_enter);
         res.point_z  = entry_coord(org[2], dir[2], t_enter);
      end else begin
         res.hit      = 1'b0;
         res.distance = -(32'sd1 <<< FRAC_BITS);
         res.point_x  = r.origin_x;
         res.point_y  = r.origin_y;
         res.point_z  = r.origin_z;
      end
      return res;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'h8000_0000 + $urandom_range(0, 3);
         2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3:       return 32'(int'($urandom_range(0, 8)) - 4) <<< FRAC_BITS;
         4:       return 32'd0;
         default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   // Random rays built from small values, zeros, range extremes and raw noise.
   function automatic ray_type random_ray();
      ray_type r;
      r.origin_x    = random_coord();
      r.origin_y    = random_coord();
      r.origin_z    = random_coord();
      r.direction_x = random_coord();
      r.direction_y = random_coord();
      r.direction_z = random_coord();
      return r;
   endfunction

   // Request transfer with bursts and gaps on the sender side.
   task automatic send_ray(input ray_type r);
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      hit_queue.push_back(slab_intersect(r));
      if ($urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write; the caller drops valid after its last write.
   task automatic write_box(input csr_index_type idx, input logic [31:0] value);
      csr_if.valid         <= 1'b1;
      csr_if.payload.index <= idx;
      csr_if.payload.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx <= CSR_BOX_MIN_Z) box_lo_reg[idx] = value;
      else box_hi_reg[idx - CSR_BOX_MAX_X] = value;
   endtask

   task automatic write_all(input logic [31:0] v0, v1, v2, v3, v4, v5);
      write_box(CSR_BOX_MIN_X, v0);
      write_box(CSR_BOX_MIN_Y, v1);
      write_box(CSR_BOX_MIN_Z, v2);
      write_box(CSR_BOX_MAX_X, v3);
      write_box(CSR_BOX_MAX_Y, v4);
      write_box(CSR_BOX_MAX_Z, v5);
      csr_if.valid <= 1'b0;
   endtask

   // Receiver stall pattern and result check.
   always @(posedge clock) begin
      result_type exp_res;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (hit_queue.size() == 0) begin
               $error("result transfer with nothing expected");
               error_count++;
            end else begin
               exp_res = hit_queue.pop_front();
               if (rsp_if.payload.hit !== exp_res.hit) begin
                  $error("hit: expected %0d, got %0d", exp_res.hit, rsp_if.payload.hit);
                  error_count++;
               end
               if (rsp_if.payload.distance !== exp_res.distance) begin
                  $error("distance: expected %h, got %h", exp_res.distance,
                         rsp_if.payload.distance);
                  error_count++;
               end
               if (rsp_if.payload.point_x !== exp_res.point_x) begin
                  $error("point_x: expected %h, got %h", exp_res.point_x,
                         rsp_if.payload.point_x);
                  error_count++;
               end
               if (rsp_if.payload.point_y !== exp_res.point_y) begin
                  $error("point_y: expected %h, got %h", exp_res.point_y,
                         rsp_if.payload.point_y);
                  error_count++;
               end
               if (rsp_if.payload.point_z !== exp_res.point_z) begin
                  $error("point_z: expected %h, got %h", exp_res.point_z,
                         rsp_if.payload.point_z);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= stall_enable ? (($urandom_range(0, 15) & 3) != 0) : 1'b1;
      end
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      ray_row_type rows [$];
      ray_row_type row;
      result_type  miss;
      error_count    = 0;
      stall_enable   = 1'b0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      for (int i = 0; i < 3; i++) begin
         box_lo_reg[i] = 0;
         box_hi_reg[i] = 0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the box is the single point at the origin.
      row.ray = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                  32'sd0, 32'sd0};
      row.has_expect = 1'b1;
      row.expected = '{1'b0, -(32'sd1 <<< FRAC_BITS), 32'sh0001_0000, 32'sh0001_0000,
                       32'sh0001_0000};
      rows.push_back(row);
      row.ray = '0;
      row.expected = '{1'b1, -32'sd2147483648, 32'sd0, 32'sd0, 32'sd0};
      rows.push_back(row);
      foreach (rows[i]) begin
         hit_queue.push_back(rows[i].expected);
         req_if.valid   <= 1'b1;
         req_if.payload <= rows[i].ray;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
      end
      drain();

      // Unit box, swapped bounds on y; directed extremes through the predictor.
      write_all(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000,
                32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
      rows.delete();
      row.has_expect = 1'b0;
      row.ray = '{-32'sh0005_0000, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0};
      rows.push_back(row);
      row.ray = '{32'sh0005_0000, 32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0, 32'sd0};
      rows.push_back(row);
      row.ray = '{32'sh0001_0000, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd1};
      rows.push_back(row);
      row.ray = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      rows.push_back(row);
      row.ray = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      rows.push_back(row);
      row.ray = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1};
      rows.push_back(row);
      row.ray = '{32'sd0, 32'sd0, -32'sh0003_0000, 32'sd1, 32'hFFFF_FFFF, 32'sd1};
      rows.push_back(row);
      foreach (rows[i]) send_ray(rows[i].ray);
      drain();

      // Random part over several boxes, the extremes among them.
      stall_enable = 1'b1;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            1: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            default: write_all(random_coord(), random_coord(), random_coord(),
                               random_coord(), random_coord(), random_coord());
         endcase
         for (int n = 0; n < RANDOM_RAYS / 6; n++) send_ray(random_ray());
         drain();
      end

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rbsi_pkg.sv
design/rbsi_channel_if.sv
design/rbsi_div_cell.sv
design/ray_box_slab_intersect.sv
tb/testbench.sv
